>>> rtl/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// Shared constants and types for the RGB Sobel edge magnitude block.
// ----------------------------------------------------------------------------
`default_nettype none

package sem_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 16;
  localparam int ROW_W      = HEIGHT_W + 1;  // input row runs past height while draining
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int GRAD_W     = 12;
  localparam int ABS_W      = GRAD_W - 1;
  localparam int SUM_W      = 21;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd768;
  localparam logic [CH_W-1:0]     MAG_MAX      = 8'd255;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_CALC = 6'b000100,
    S_SQ   = 6'b001000,
    S_ROOT = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

endpackage

`default_nettype wire

>>> rtl/sem_ram.sv
// ----------------------------------------------------------------------------
// sem_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/sem_mag.sv
// ----------------------------------------------------------------------------
// sem_mag
// Rounded integer square root of a sum of squares, one result bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_mag (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [sem_pkg::SUM_W-1:0] s,
  output logic                           done,
  output logic      [sem_pkg::CH_W-1:0]  mag
);
  import sem_pkg::*;

  logic [SUM_W-1:0] sv;
  logic [CH_W-1:0]  n;
  logic [2:0]       k;
  logic             busy;
  logic             rnd;
  logic [CH_W-1:0]  t;
  logic [2*CH_W-1:0] tt;
  logic [2*CH_W:0]  nn;

  always_comb begin
    t  = n | (CH_W'(1) << k);
    tt = t * t;
    nn = (2*CH_W+1)'(n) * (2*CH_W+1)'(n) + (2*CH_W+1)'(n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        k    <= 3'd7;
        n    <= '0;
        sv   <= s;
      end else if (busy) begin
        if (SUM_W'(tt) <= sv) begin
          n <= t;
        end
        if (k == 3'd0) begin
          busy <= 1'b0;
          rnd  <= 1'b1;
        end else begin
          k <= k - 3'd1;
        end
      end else if (rnd) begin
        // round up when s lies above n*n + n; large sums saturate
        rnd  <= 1'b0;
        done <= 1'b1;
        if (sv > SUM_W'(nn) && n != MAG_MAX) begin
          mag <= n + CH_W'(1);
        end else begin
          mag <= n;
        end
      end
    end
  end

  a_done_after_round: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(rnd))
    else $error("magnitude done without rounding step");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(busy && rnd))
    else $error("root iteration and rounding overlap");
  a_iter_to_round: assert property (@(posedge clk) disable iff (rst)
    (busy && !start && k == 3'd0) |=> rnd)
    else $error("rounding step missing after last bit");

endmodule

`default_nettype wire

>>> rtl/sobel_edge_magnitude_rgb.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb
// 3x3 Sobel edge magnitude per color plane on a raster RGB pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries red, green, blue and flush.
//   Output channel (out_valid / out_stall) carries edge_red, edge_green,
//   edge_blue and frame_last. A transaction completes when valid is high and
//   stall is low. Results trail pixels by image_width+1 positions; after the
//   last pixel send image_width+1 flush items to drain the frame. frame_last
//   marks the result for the bottom-right pixel.
//   Configuration writes (cfg_valid / cfg_ready, index 0 width, 1 height) are
//   taken only while idle; a write to either index restarts the frame.
// Throughput: one item at a time. An item that yields a result goes through
//   line store read, gradient, square, eight root iterations, round and
//   hand-off; one that yields none only through the line store read, and an
//   ignored flush is accepted in idle. The bit-serial square root dominates.
// Reset: counters, window and output valid clear; line stores are not cleared.
// A stalled result sits in the output register while the next item is taken;
//   a second result waits in the hand-off state until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_edge_magnitude_rgb (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [sem_pkg::CH_W-1:0]       red,
  input  wire logic [sem_pkg::CH_W-1:0]       green,
  input  wire logic [sem_pkg::CH_W-1:0]       blue,
  input  wire logic                           flush,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [sem_pkg::CH_W-1:0]       edge_red,
  output logic      [sem_pkg::CH_W-1:0]       edge_green,
  output logic      [sem_pkg::CH_W-1:0]       edge_blue,
  output logic                                frame_last,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sem_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sem_pkg::*;

  state_t              state;
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [COL_W-1:0]    in_column;
  logic [ROW_W-1:0]    in_row;
  logic [COL_W-1:0]    out_column;
  logic [HEIGHT_W-1:0] out_row;
  logic [COL_W-1:0]    col_q;
  logic [PIX_W-1:0]    pix_q;
  logic                ready_q;
  logic                last_q;
  logic [PIX_W-1:0]    win [3][3];
  logic [PIX_W-1:0]    up_data;
  logic [PIX_W-1:0]    mid_data;
  logic [ABS_W-1:0]    ax [3];
  logic [ABS_W-1:0]    ay [3];
  logic [SUM_W-1:0]    s_sum [3];
  logic [CH_W-1:0]     mag [3];
  logic [2:0]          mag_done;

  logic in_acc, cfg_acc, complete, take_item;
  logic top_ok, bot_ok, left_ok, right_ok, last;
  logic [WIDTH_W-1:0] in_col_inc, out_col_inc;
  logic [HEIGHT_W:0]  out_row_inc;
  logic signed [GRAD_W-1:0] gx [3];
  logic signed [GRAD_W-1:0] gy [3];
  logic signed [GRAD_W-1:0] v [3][3];
  logic out_load;

  assign w_eff = (width_reg == '0) ? WIDTH_W'(1) :
                 (width_reg > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : width_reg;
  assign h_eff = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;

  // a pending register write holds off pixel input
  assign in_stall  = (state != S_IDLE) || cfg_valid;
  assign cfg_ready = (state == S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign complete  = in_row >= ROW_W'(h_eff);
  assign take_item = in_acc && (complete || !flush);

  assign in_col_inc  = WIDTH_W'(in_column) + WIDTH_W'(1);
  assign out_col_inc = WIDTH_W'(out_column) + WIDTH_W'(1);
  assign out_row_inc = (HEIGHT_W+1)'(out_row) + (HEIGHT_W+1)'(1);

  assign top_ok   = out_row != '0;
  assign bot_ok   = out_row_inc < (HEIGHT_W+1)'(h_eff);
  assign left_ok  = out_column != '0;
  assign right_ok = out_col_inc < w_eff;
  assign last     = !bot_ok && !right_ok;

  // line stores: upper holds the row two above, middle the row above
  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (state == S_READ),
    .waddr (col_q),
    .wdata (mid_data),
    .raddr (in_column),
    .rdata (up_data)
  );

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (state == S_READ),
    .waddr (col_q),
    .wdata (pix_q),
    .raddr (in_column),
    .rdata (mid_data)
  );

  // masked window taps and gradients, one set per plane
  always_comb begin
    for (int p = 0; p < 3; p++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if ((i == 0 && !top_ok) || (i == 2 && !bot_ok) ||
              (j == 0 && !left_ok) || (j == 2 && !right_ok)) begin
            v[i][j] = '0;
          end else begin
            v[i][j] = $signed({4'b0, win[i][j][PIX_W-CH_W*(p+1) +: CH_W]});
          end
        end
      end
      gx[p] = (v[0][2] - v[0][0]) + ((v[1][2] - v[1][0]) <<< 1) + (v[2][2] - v[2][0]);
      gy[p] = (v[2][0] + (v[2][1] <<< 1) + v[2][2]) - (v[0][0] + (v[0][1] <<< 1) + v[0][2]);
    end
  end

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      s_sum[p] = SUM_W'((2*ABS_W)'(ax[p]) * (2*ABS_W)'(ax[p])
                      + (2*ABS_W)'(ay[p]) * (2*ABS_W)'(ay[p]));
    end
  end

  for (genvar p = 0; p < 3; p++) begin : g_mag
    sem_mag u_mag (
      .clk   (clk),
      .rst   (rst),
      .start (state == S_SQ),
      .s     (s_sum[p]),
      .done  (mag_done[p]),
      .mag   (mag[p])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cfg_acc && (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT)) begin
            if (cfg_index == CFG_IMAGE_WIDTH) begin
              width_reg <= cfg_data[WIDTH_W-1:0];
            end else begin
              height_reg <= cfg_data;
            end
            in_column  <= '0;
            in_row     <= '0;
            out_column <= '0;
            out_row    <= '0;
            for (int i = 0; i < 3; i++) begin
              for (int j = 0; j < 3; j++) begin
                win[i][j] <= '0;
              end
            end
          end else if (take_item) begin
            pix_q   <= complete ? '0 : {red, green, blue};
            col_q   <= in_column;
            ready_q <= (in_row >= ROW_W'(2)) || (in_row == ROW_W'(1) && in_column != '0);
            if (in_col_inc >= w_eff) begin
              in_column <= '0;
              in_row    <= in_row + ROW_W'(1);
            end else begin
              in_column <= in_column + COL_W'(1);
            end
            state <= S_READ;
          end
        end
        S_READ: begin
          for (int i = 0; i < 3; i++) begin
            win[i][0] <= win[i][1];
            win[i][1] <= win[i][2];
          end
          win[0][2] <= up_data;
          win[1][2] <= mid_data;
          win[2][2] <= pix_q;
          state     <= ready_q ? S_CALC : S_IDLE;
        end
        S_CALC: begin
          for (int p = 0; p < 3; p++) begin
            ax[p] <= gx[p][GRAD_W-1] ? ABS_W'(-gx[p]) : ABS_W'(gx[p]);
            ay[p] <= gy[p][GRAD_W-1] ? ABS_W'(-gy[p]) : ABS_W'(gy[p]);
          end
          last_q <= last;
          if (last) begin
            in_column  <= '0;
            in_row     <= '0;
            out_column <= '0;
            out_row    <= '0;
            for (int i = 0; i < 3; i++) begin
              for (int j = 0; j < 3; j++) begin
                win[i][j] <= '0;
              end
            end
          end else if (!right_ok) begin
            out_column <= '0;
            out_row    <= out_row + HEIGHT_W'(1);
          end else begin
            out_column <= out_column + COL_W'(1);
          end
          state <= S_SQ;
        end
        S_SQ: begin
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (mag_done[0]) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign out_load = (state == S_EMIT) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      edge_red   <= mag[0];
      edge_green <= mag[1];
      edge_blue  <= mag[2];
      frame_last <= last_q;
    end
  end

  a_take_to_read: assert property (@(posedge clk) disable iff (rst)
    (take_item && !cfg_acc) |=> state == S_READ)
    else $error("accepted item did not start a line store read");
  a_done_in_root: assert property (@(posedge clk) disable iff (rst)
    mag_done[0] |-> state == S_ROOT)
    else $error("root result outside its wait state");
  a_planes_in_step: assert property (@(posedge clk) disable iff (rst)
    mag_done[0] == mag_done[1] && mag_done[1] == mag_done[2])
    else $error("plane root units out of step");
  a_out_col_range: assert property (@(posedge clk) disable iff (rst)
    WIDTH_W'(out_column) < w_eff || $past(cfg_acc))
    else $error("output column beyond frame width");

endmodule

`default_nettype wire

>>> verif/tb_sobel_edge_magnitude_rgb.sv
// ----------------------------------------------------------------------------
// tb_sobel_edge_magnitude_rgb
// Self-checking bench: drives raster RGB frames with drain flushes, predicts
// the per-plane Sobel magnitudes in step and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sobel_edge_magnitude_rgb;
  import sem_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd2;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 24;
  localparam int PARTIAL_MAX = 40;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    logic            last;
  } edge_t;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [CH_W-1:0]       r, g, b;
    bit                    fl;
    bit                    has_exp;
    edge_t                 exp_edge;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_stall;
  logic [CH_W-1:0] red = '0, green = '0, blue = '0;
  logic flush = 1'b0;
  logic out_valid, out_stall = 1'b0;
  logic [CH_W-1:0] edge_red, edge_green, edge_blue;
  logic frame_last;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #10 clk = ~clk;

  sobel_edge_magnitude_rgb DUT (.*);

  // predictor state
  logic [PIX_W-1:0] upper_row [MAX_WIDTH];
  logic [PIX_W-1:0] middle_row [MAX_WIDTH];
  logic [PIX_W-1:0] win [9];
  int unsigned col_in, row_in, col_out, row_out;
  logic [WIDTH_W-1:0] width_reg;
  logic [HEIGHT_W-1:0] height_reg;

  edge_t pending_edges[$];
  int errors = 0, idle_cycles = 0;
  int pixels_sent = 0, edges_seen = 0, frames_done = 0, cfg_writes = 0;
  int tx_pct = 0, rx_pct = 0;

  task automatic report_mismatch(input string what);
    errors++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  function automatic int unsigned eff_w();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned eff_h();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic logic [CH_W-1:0] round_root(input int gx, input int gy);
    int unsigned s, n, t;
    s = gx * gx + gy * gy;
    if (s > 65280) return MAG_MAX;
    n = 0;
    for (int bit_w = 128; bit_w != 0; bit_w >>= 1) begin
      t = n | bit_w;
      if (t * t <= s) n = t;
    end
    if (s > n * n + n) n++;
    return (n > 255) ? MAG_MAX : n[CH_W-1:0];
  endfunction

  task automatic restart_frame();
    foreach (win[i]) win[i] = '0;
    col_in = 0; row_in = 0; col_out = 0; row_out = 0;
  endtask

  task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    if (idx == CFG_IMAGE_WIDTH) begin
      width_reg = d[WIDTH_W-1:0];
      restart_frame();
    end else if (idx == CFG_IMAGE_HEIGHT) begin
      height_reg = d;
      restart_frame();
    end
  endtask

  // advance the edge predictor by one accepted transaction
  task automatic sobel_advance(input logic [CH_W-1:0] r, g, b, input bit fl,
                               output bit got, output edge_t res);
    int unsigned w, h, c;
    bit complete, ready, top_ok, bot_ok, left_ok, right_ok;
    logic [PIX_W-1:0] pix, up, mid;
    int gx, gy, v;
    logic [CH_W-1:0] mag [3];
    w = eff_w(); h = eff_h();
    got = 0; res = '0;
    complete = row_in >= h;
    if (!complete && fl) return;
    pix = complete ? '0 : {r, g, b};
    c = (col_in < MAX_WIDTH) ? col_in : MAX_WIDTH - 1;
    up = upper_row[c]; mid = middle_row[c];
    upper_row[c] = mid; middle_row[c] = pix;
    for (int i = 0; i < 3; i++) begin
      win[i*3] = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = up; win[5] = mid; win[8] = pix;
    ready = row_in >= 2 || (row_in == 1 && col_in >= 1);
    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      row_in++;
    end
    if (!ready) return;
    top_ok = row_out != 0; bot_ok = row_out + 1 < h;
    left_ok = col_out != 0; right_ok = col_out + 1 < w;
    for (int p = 0; p < 3; p++) begin
      gx = 0; gy = 0;
      for (int i = 0; i < 3; i++) begin
        if ((i == 0 && !top_ok) || (i == 2 && !bot_ok)) continue;
        for (int j = 0; j < 3; j++) begin
          if ((j == 0 && !left_ok) || (j == 2 && !right_ok)) continue;
          v = (win[i*3+j] >> (16 - 8 * p)) & 8'hFF;
          gx += v * (j - 1) * ((i == 1) ? 2 : 1);
          gy += v * (i - 1) * ((j == 1) ? 2 : 1);
        end
      end
      mag[p] = round_root(gx, gy);
    end
    got = 1;
    res.r = mag[0]; res.g = mag[1]; res.b = mag[2];
    res.last = row_out + 1 >= h && col_out + 1 >= w;
    col_out++;
    if (col_out >= w) begin
      col_out = 0;
      row_out++;
    end
    if (res.last) begin
      frames_done++;
      restart_frame();
    end
  endtask

  // result checker and output stall
  always @(posedge clk) begin
    edge_t exp_e;
    if (!rst) begin
      out_stall <= ($urandom_range(99) < rx_pct);
      if (out_valid && !out_stall) begin
        edges_seen++;
        if (pending_edges.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          exp_e = pending_edges.pop_front();
          if (edge_red !== exp_e.r)
            report_mismatch($sformatf("edge_red %0d exp %0d", edge_red, exp_e.r));
          if (edge_green !== exp_e.g)
            report_mismatch($sformatf("edge_green %0d exp %0d", edge_green, exp_e.g));
          if (edge_blue !== exp_e.b)
            report_mismatch($sformatf("edge_blue %0d exp %0d", edge_blue, exp_e.b));
          if (frame_last !== exp_e.last)
            report_mismatch($sformatf("frame_last %0b exp %0b", frame_last, exp_e.last));
        end
      end
    end
  end

  // watchdog: cycles with no transaction on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_edges.size());
      $display("[sobel_edge_magnitude_rgb] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input logic [CH_W-1:0] r, g, b, input bit fl,
                           input bit has_exp = 0, input edge_t exp_e = '0);
    bit got;
    edge_t res;
    if ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    red <= r; green <= g; blue <= b; flush <= fl;
    do @(posedge clk); while (in_stall);
    if (!fl) pixels_sent++;
    sobel_advance(r, g, b, fl, got, res);
    if (has_exp) begin
      if (!got || res !== exp_e) report_mismatch("table row disagrees with predictor");
      pending_edges.push_back(exp_e);
    end else if (got) begin
      pending_edges.push_back(res);
    end
  endtask

  // drain outstanding results, then let the block finish internal work
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    settle();
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    apply_cfg(idx, d);
  endtask

  // one frame: pixels with stray flushes, then drain; or cut short
  task automatic run_frame(input int wd, input int ht, input bit partial);
    int unsigned w, h, n;
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(wd));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(ht));
    w = eff_w(); h = eff_h();
    n = partial ? $urandom_range(1, (w * h > PARTIAL_MAX) ? PARTIAL_MAX : w * h) : w * h;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 5)
        send_item(CH_W'($urandom), CH_W'($urandom), CH_W'($urandom), 1'b1);
      send_item(CH_W'($urandom), CH_W'($urandom), CH_W'($urandom), 1'b0);
    end
    if (partial) return;
    for (int k = 0; k <= w; k++)
      send_item(CH_W'($urandom), CH_W'($urandom), CH_W'($urandom),
                $urandom_range(99) >= 25);
    repeat ($urandom_range(0, 2))
      send_item(CH_W'($urandom), CH_W'($urandom), CH_W'($urandom), 1'b1);
  endtask

  stim_row_t dir_rows[$];

  initial begin
    stim_row_t row;
    logic [CH_W-1:0] pr[9], pg[9], pb[9];
    int target;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_row[i] = '0;
      middle_row[i] = '0;
    end
    width_reg = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    restart_frame();

    // single-pixel frame: ignored early flush, drain carrying pixel data,
    // flush after the marked result, write to an unused index
    row = '{default: '0};
    row.is_cfg = 1; row.idx = CFG_IMAGE_WIDTH; row.data = 1; dir_rows.push_back(row);
    row.idx = CFG_IMAGE_HEIGHT; dir_rows.push_back(row);
    row = '{default: '0};
    row.fl = 1; dir_rows.push_back(row);
    row.fl = 0; row.r = 8'hFF; row.g = 8'hFF; row.b = 8'hFF; dir_rows.push_back(row);
    row.r = 12; row.g = 34; row.b = 56; dir_rows.push_back(row);
    row = '{default: '0};
    row.fl = 1; row.has_exp = 1; row.exp_edge = '{r: 0, g: 0, b: 0, last: 1};
    dir_rows.push_back(row);
    row.has_exp = 0; dir_rows.push_back(row);
    row = '{default: '0};
    row.is_cfg = 1; row.idx = CFG_UNUSED; row.data = 16'hFFFF; dir_rows.push_back(row);
    row.idx = CFG_IMAGE_WIDTH; row.data = 3; dir_rows.push_back(row);
    row.idx = CFG_IMAGE_HEIGHT; dir_rows.push_back(row);
    // 3x3 of full-scale planes, hits the clamp
    pr = '{8'hFF, 0, 0, 8'hFF, 0, 8'hFF, 0, 0, 8'hFF};
    pg = '{0, 8'hFF, 0, 8'hFF, 0, 8'hFF, 0, 8'hFF, 0};
    pb = '{0, 0, 8'hFF, 8'hFF, 0, 8'hFF, 8'hFF, 0, 0};
    for (int i = 0; i < 9; i++) begin
      row = '{default: '0};
      row.r = pr[i]; row.g = pg[i]; row.b = pb[i];
      dir_rows.push_back(row);
    end
    for (int i = 0; i < 4; i++) begin
      row = '{default: '0};
      row.fl = (i != 2);
      row.r = 8'hA5; row.g = 8'h5A; row.b = 8'hC3;
      dir_rows.push_back(row);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_reg(dir_rows[i].idx, dir_rows[i].data);
      else send_item(dir_rows[i].r, dir_rows[i].g, dir_rows[i].b, dir_rows[i].fl,
                     dir_rows[i].has_exp, dir_rows[i].exp_edge);
    end

    for (int ph = 0; ph < 3; ph++) begin
      tx_pct = (ph == 0) ? 9 : (ph == 1) ? 75 : 0;
      rx_pct = (ph == 0) ? 75 : (ph == 1) ? 9 : 0;
      case (ph)
        0: run_frame(0, 0, 0);
        1: run_frame(5, 65535, 1);
        default: begin
          run_frame(2047, 1, 1);
          run_frame(1024, 2, 1);
        end
      endcase
      target = pixels_sent + 150;
      while (pixels_sent < target)
        run_frame($urandom_range(1, 8), $urandom_range(1, 5), $urandom_range(99) < 10);
    end

    settle();
    $display("covered %0d pixels, %0d results, %0d full frames, %0d register writes",
             pixels_sent, edges_seen, frames_done, cfg_writes);
    if (errors == 0) $display("[sobel_edge_magnitude_rgb] OK");
    else $display("[sobel_edge_magnitude_rgb] ERROR");
    $finish;
  end

endmodule
